### sv/md5_pkg.sv
`default_nettype none

package md5_pkg;

   // request and response words
   typedef struct packed {
      logic [31:0] message_word;
      logic        new_message;
   } md5_req_type;

   typedef struct packed {
      logic [31:0] digest_a;
      logic [31:0] digest_b;
      logic [31:0] digest_c;
      logic [31:0] digest_d;
   } md5_rsp_type;

   // control sequence
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ROUND,
      ST_DONE
   } md5_state_type;

   localparam logic [3:0] LAST_WORD  = 4'd15;
   localparam logic [5:0] LAST_ROUND = 6'd63;

   // round groups, taken from the top two bits of the round number
   localparam logic [1:0] GRP_F = 2'd0;
   localparam logic [1:0] GRP_G = 2'd1;
   localparam logic [1:0] GRP_H = 2'd2;
   localparam logic [1:0] GRP_I = 2'd3;

   localparam logic [31:0] MD5_IV [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [31:0] K_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // rotation amount: depends on the group and the round within four
   function automatic logic [4:0] md5_shift(input logic [5:0] rnd);
      logic [3:0] sel;
      sel = {rnd[5:4], rnd[1:0]};
      case (sel)
         4'd0:    md5_shift = 5'd7;
         4'd1:    md5_shift = 5'd12;
         4'd2:    md5_shift = 5'd17;
         4'd3:    md5_shift = 5'd22;
         4'd4:    md5_shift = 5'd5;
         4'd5:    md5_shift = 5'd9;
         4'd6:    md5_shift = 5'd14;
         4'd7:    md5_shift = 5'd20;
         4'd8:    md5_shift = 5'd4;
         4'd9:    md5_shift = 5'd11;
         4'd10:   md5_shift = 5'd16;
         4'd11:   md5_shift = 5'd23;
         4'd12:   md5_shift = 5'd6;
         4'd13:   md5_shift = 5'd10;
         4'd14:   md5_shift = 5'd15;
         default: md5_shift = 5'd21;
      endcase
   endfunction

   // message word schedule, all arithmetic modulo 16
   function automatic logic [3:0] md5_msg_index(input logic [5:0] rnd);
      logic [3:0] x;
      x = rnd[3:0];
      case (rnd[5:4])
         GRP_F:   md5_msg_index = x;
         GRP_G:   md5_msg_index = 4'(x + (x << 2) + 4'd1);
         GRP_H:   md5_msg_index = 4'(x + (x << 1) + 4'd5);
         default: md5_msg_index = 4'((x << 3) - x);
      endcase
   endfunction

   // round mixing function
   function automatic logic [31:0] md5_mix(input logic [1:0]  grp,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
      case (grp)
         GRP_F:   md5_mix = (b & c) | (~b & d);
         GRP_G:   md5_mix = (d & b) | (~d & c);
         GRP_H:   md5_mix = b ^ c ^ d;
         default: md5_mix = c ^ (b | ~d);
      endcase
   endfunction

   function automatic logic [31:0] md5_rotl(input logic [31:0] x,
                                            input logic [4:0]  n);
      logic [63:0] t;
      t = {x, x} << n;
      md5_rotl = t[63:32];
   endfunction

endpackage

`default_nettype wire

### sv/md5_chan_if.sv
`default_nettype none

interface md5_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/md5_block_compression.sv
// MD5 block compression engine.
// req_chan (sink, md5_req_type payload) takes one padded 32-bit message word
// per handshake; new_message on a word restarts the chaining value at the
// MD5 initial value and makes that word the first of a fresh block.
// rsp_chan (source, md5_rsp_type payload) gives the four chaining words once
// per sixteen words taken; a partial block gives nothing.
// Words are taken one per cycle while loading. After the sixteenth word
// the block runs 64 rounds, one per cycle, reading the buffered words from
// a 16-entry buffer memory with a registered read port, then does the final
// add, which waits while a response is pending and rsp ready is low. No word
// is taken during the rounds or the final add.
// The response sits in an output register; while it waits, the next block
// is loaded, and only the final add of that next block waits on rsp ready.
// Synchronous reset clears the word count, restores the initial chaining
// value and drops any pending response; buffer contents are not cleared.
`default_nettype none

module md5_block_compression (
   input  wire logic   clock,
   input  wire logic   reset,
   md5_chan_if.sink    req_chan,
   md5_chan_if.source  rsp_chan
);
   import md5_pkg::*;

   md5_state_type state_ff, state_in;
   logic [3:0]    count_ff, count_in;
   logic [5:0]    round_ff, round_in;
   logic [31:0]   a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [31:0]   chain_ff [4];
   logic [31:0]   chain_in [4];
   md5_rsp_type   rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [31:0]   buf_mem [16];
   logic [31:0]   rd_data_ff;
   logic [3:0]    rd_addr;
   logic [3:0]    wr_idx;

   logic          req_ready;
   logic          accept;
   logic          last_word;
   logic          done_fire;
   logic [31:0]   start_chain [4];
   logic [31:0]   round_sum;
   logic [31:0]   b_new;

   // fsm outputs
   always_comb begin
      req_ready = (state_ff == ST_LOAD);
      accept    = req_chan.valid & req_ready;
      wr_idx    = req_chan.payload.new_message ? 4'd0 : count_ff;
      last_word = accept & (wr_idx == LAST_WORD);
      done_fire = (state_ff == ST_DONE) & (~rsp_valid_ff | rsp_chan.ready);
   end

   // fsm next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (last_word) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == LAST_ROUND) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (done_fire) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // word count and round count
   always_comb begin
      count_in = count_ff;
      if (accept) count_in = last_word ? 4'd0 : 4'(wr_idx + 4'd1);
      round_in = '0;
      if (state_ff == ST_ROUND) round_in = 6'(round_ff + 6'd1);
   end

   // buffer read address runs one round ahead; in loading it sits on the
   // first word of round zero. The word written at the sixteenth handshake
   // is entry fifteen, never the entry read then, so no forwarding is needed
   always_comb begin
      rd_addr = md5_msg_index(6'd0);
      if (state_ff == ST_ROUND) rd_addr = md5_msg_index(6'(round_ff + 6'd1));
   end

   // block buffer memory
   always_ff @(posedge clock) begin
      if (accept) buf_mem[wr_idx] <= req_chan.payload.message_word;
      rd_data_ff <= buf_mem[rd_addr];
   end

   // one md5 round
   always_comb begin
      round_sum = a_ff + md5_mix(round_ff[5:4], b_ff, c_ff, d_ff)
                  + K_TABLE[round_ff] + rd_data_ff;
      b_new     = b_ff + md5_rotl(round_sum, md5_shift(round_ff));
   end

   // working words and chaining value
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         start_chain[i] = req_chan.payload.new_message ? MD5_IV[i] : chain_ff[i];
         chain_in[i]    = chain_ff[i];
      end
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      rsp_in = rsp_ff;
      if (accept) begin
         for (int i = 0; i < 4; i++) chain_in[i] = start_chain[i];
      end
      if (last_word) begin
         a_in = start_chain[0];
         b_in = start_chain[1];
         c_in = start_chain[2];
         d_in = start_chain[3];
      end
      if (state_ff == ST_ROUND) begin
         a_in = d_ff;
         b_in = b_new;
         c_in = b_ff;
         d_in = c_ff;
      end
      if (done_fire) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         rsp_in.digest_a = chain_in[0];
         rsp_in.digest_b = chain_in[1];
         rsp_in.digest_c = chain_in[2];
         rsp_in.digest_d = chain_in[3];
      end
   end

   // response handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) rsp_valid_in = 1'b0;
      if (done_fire) rsp_valid_in = 1'b1;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) chain_ff[i] <= MD5_IV[i];
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 4; i++) chain_ff[i] <= chain_in[i];
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      rsp_ff <= rsp_in;
   end

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // a response only appears out of the final add
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the final add");

   // rounds advance one per cycle
   a_round_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) && (round_ff != LAST_ROUND)
      |=> (state_ff == ST_ROUND) && (round_ff == 6'($past(round_ff) + 6'd1)))
      else $error("round counter skipped");

   // the sixteenth word starts round zero
   a_block_start: assert property (@(posedge clock) disable iff (reset)
      last_word |=> (state_ff == ST_ROUND) && (round_ff == 6'd0))
      else $error("block did not start at round zero");

   // word count is idle at zero while compressing
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (count_ff == 4'd0))
      else $error("word count moved during compression");

endmodule

`default_nettype wire

### sim/tb_md5_block_compression.sv
`default_nettype none

module tb_md5_block_compression;
   import md5_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 100;

   // standard chaining start value
   localparam logic [31:0] INIT_CHAIN [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   // per-round sine constants
   localparam logic [31:0] SINE_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // rotation amounts, four per round group
   localparam int ROT_AMT [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   logic clock = 1'b0;
   logic reset;

   md5_chan_if #(.payload_type(md5_req_type)) req_if ();
   md5_chan_if #(.payload_type(md5_rsp_type)) rsp_if ();

   md5_block_compression dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #2 clock = ~clock;

   // predictor state
   logic [31:0] chain_words [4];
   logic [31:0] block_words [16];
   logic [3:0]  word_index;
   md5_rsp_type digest_queue [$];
   md5_rsp_type last_digest;

   int error_count = 0;
   int words_sent = 0;
   int digests_checked = 0;
   int cycle_count = 0;
   int req_idle_pct = 34;
   int rsp_idle_pct = 34;
   int hold_request = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      error_count++;
   endtask

   // take one word into the predicted block, compress on the sixteenth
   task automatic absorb_word(input logic [31:0] word, input logic start);
      logic [31:0] a, b, c, d, mix, sum, held;
      logic [5:0]  rnd;
      logic [1:0]  grp;
      int          pick, amt;
      if (start) begin
         for (int i = 0; i < 4; i++) chain_words[i] = INIT_CHAIN[i];
         word_index = '0;
      end
      block_words[word_index] = word;
      if (word_index != 4'd15) begin
         word_index = word_index + 4'd1;
      end else begin
         word_index = '0;
         a = chain_words[0];
         b = chain_words[1];
         c = chain_words[2];
         d = chain_words[3];
         for (int r = 0; r < 64; r++) begin
            rnd = r[5:0];
            grp = rnd[5:4];
            case (grp)
               GRP_F: begin
                  mix  = (b & c) | (~b & d);
                  pick = r % 16;
               end
               GRP_G: begin
                  mix  = (d & b) | (~d & c);
                  pick = (5 * r + 1) % 16;
               end
               GRP_H: begin
                  mix  = b ^ c ^ d;
                  pick = (3 * r + 5) % 16;
               end
               default: begin
                  mix  = c ^ (b | ~d);
                  pick = (7 * r) % 16;
               end
            endcase
            amt  = ROT_AMT[4 * int'(grp) + r % 4];
            sum  = a + mix + SINE_TABLE[r] + block_words[pick];
            held = d;
            d    = c;
            c    = b;
            b    = b + ((sum << amt) | (sum >> (32 - amt)));
            a    = held;
         end
         chain_words[0] = chain_words[0] + a;
         chain_words[1] = chain_words[1] + b;
         chain_words[2] = chain_words[2] + c;
         chain_words[3] = chain_words[3] + d;
         last_digest.digest_a = chain_words[0];
         last_digest.digest_b = chain_words[1];
         last_digest.digest_c = chain_words[2];
         last_digest.digest_d = chain_words[3];
         digest_queue.push_back(last_digest);
      end
   endtask

   // offer one word, with random idle cycles ahead of it
   task automatic send_word(input logic [31:0] word, input logic start);
      md5_req_type item;
      item.message_word = word;
      item.new_message  = start;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      absorb_word(word, start);
      words_sent++;
   endtask

   // withdraw the last word, then wait for the digests to drain
   task automatic wait_for_digests();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0:       pick_word = '0;
         1:       pick_word = '1;
         2:       pick_word = 32'h1 << $urandom_range(31);
         3:       pick_word = ~(32'h1 << $urandom_range(31));
         default: pick_word = $urandom();
      endcase
   endfunction

   // padded empty message straight after reset, then "abc" as a fresh message
   task automatic test_known_answers();
      send_word(32'h00000080, 1'b0);
      for (int i = 1; i < 16; i++) send_word(32'h0, 1'b0);
      if (last_digest.digest_a != 32'hd98c1dd4)
         report_mismatch("empty message digest a", last_digest.digest_a, 32'hd98c1dd4);
      if (last_digest.digest_d != 32'h7e42f8ec)
         report_mismatch("empty message digest d", last_digest.digest_d, 32'h7e42f8ec);
      send_word(32'h80636261, 1'b1);
      for (int i = 1; i < 16; i++) send_word((i == 14) ? 32'd24 : 32'h0, 1'b0);
      if (last_digest.digest_b != 32'hb04fd23c)
         report_mismatch("abc digest b", last_digest.digest_b, 32'hb04fd23c);
      if (last_digest.digest_c != 32'h7d3f96d6)
         report_mismatch("abc digest c", last_digest.digest_c, 32'h7d3f96d6);
   endtask

   // all-ones block chained on from the previous message
   task automatic test_chained_extremes();
      for (int i = 0; i < 16; i++) send_word('1, 1'b0);
   endtask

   // a partial block dropped by a restart part way through
   task automatic test_partial_restart();
      for (int i = 0; i < 5; i++) send_word(pick_word(), i == 0);
      for (int i = 0; i < 16; i++) send_word(32'h1 << (2 * i), i == 0);
   endtask

   // receiver holds off long enough for the input side to back up
   task automatic test_output_stall();
      wait_for_digests();
      req_idle_pct = 0;
      hold_request = 400;
      for (int i = 0; i < 48; i++) send_word(pick_word(), i == 0);
      wait_for_digests();
      req_idle_pct = 34;
   endtask

   // mostly whole messages, some partial blocks and loose words
   task automatic test_random_traffic(input int target);
      int first_count, kind, len, msgs, done;
      first_count = words_sent;
      msgs = 0;
      while (words_sent - first_count < target) begin
         done = words_sent - first_count;
         // quiet stretch with no idling on either side
         if (done > target / 3 && done < target / 2) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 34;
            rsp_idle_pct = 34;
         end
         kind = $urandom_range(99);
         if (kind < 75) begin
            len = 16 * $urandom_range(1, 4);
            for (int i = 0; i < len; i++) send_word(pick_word(), i == 0);
         end else if (kind < 90) begin
            len = $urandom_range(1, 15);
            for (int i = 0; i < len; i++)
               send_word(pick_word(), (i == 0) && ($urandom_range(1) == 1));
         end else begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) send_word(pick_word(), $urandom_range(9) == 0);
         end
         msgs++;
         // sender pause until every digest is out
         if (msgs % 8 == 0) wait_for_digests();
      end
      req_idle_pct = 34;
      rsp_idle_pct = 34;
   endtask

   // receiver ready: random stalls plus an occasional long hold-off
   always @(negedge clock) begin : drive_ready
      int hold_left;
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // compare each digest with the oldest prediction
   always @(posedge clock) begin : check_digest
      md5_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (digest_queue.size() == 0) begin
            report_mismatch("digest with none pending", rsp_if.payload.digest_a, '0);
         end else begin
            want = digest_queue.pop_front();
            if (rsp_if.payload.digest_a != want.digest_a)
               report_mismatch("digest_a", rsp_if.payload.digest_a, want.digest_a);
            if (rsp_if.payload.digest_b != want.digest_b)
               report_mismatch("digest_b", rsp_if.payload.digest_b, want.digest_b);
            if (rsp_if.payload.digest_c != want.digest_c)
               report_mismatch("digest_c", rsp_if.payload.digest_c, want.digest_c);
            if (rsp_if.payload.digest_d != want.digest_d)
               report_mismatch("digest_d", rsp_if.payload.digest_d, want.digest_d);
            digests_checked++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d digests pending", cycle_count,
                  digest_queue.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      for (int i = 0; i < 4; i++) chain_words[i] = INIT_CHAIN[i];
      for (int i = 0; i < 16; i++) block_words[i] = '0;
      word_index = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_known_answers();
      test_chained_extremes();
      test_partial_restart();
      test_output_stall();
      test_random_traffic(1630);

      @(negedge clock);
      req_if.valid <= 1'b0;
      wait_for_digests();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d message words, checked %0d digests", words_sent, digests_checked);
      $display("known answers, chaining, partial blocks, restarts and output stalls covered");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
